FILE: src/dosc_pkg.sv
// Shared types, codes and widths of the DC offset calibrator.
`timescale 1ns / 1ps
`default_nettype none

package dosc_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int SMP_W      = 16;
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int ACC_W      = SMP_W + 1 + $clog2(MAX_SAMPLES);
    localparam int NUM_W      = ACC_W - 1;
    localparam int REM_W      = CNT_W + 1;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int QUOT_W     = SMP_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] K_SAMPLE = 2'd0;
    localparam logic [1:0] K_MARKER = 2'd1;
    localparam logic [1:0] K_START  = 2'd2;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_INTEG = 2'd2;

    localparam logic [1:0] ST_CAL  = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_GAVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_OFS = 2'd3;

    localparam logic [14:0] RST_WINDOW   = 15'd320;
    localparam logic [14:0] RST_DEADBAND = 15'd32;
    localparam logic [9:0]  RST_MAX_ITER = 10'd1000;
    localparam logic [15:0] RST_INIT_OFS = 16'h8000;

    typedef struct packed {
        logic start;
        logic sample;
        logic open;
        logic div_start;
        logic close;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] phase;
        logic       div_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: src/dosc_div.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
`default_nettype none

module dosc_div
    import dosc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [ACC_W-1:0]  i_dividend,
    input  wire logic [CNT_W-1:0]         i_divisor,
    output logic                          o_done,
    output logic signed [QUOT_W-1:0]      o_quot,
    output logic [SMP_W-1:0]              o_mag
);

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]       r_num;
    logic [REM_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_den;
    logic                   r_neg;
    logic                   r_zero;
    logic signed [QUOT_W-1:0] r_quot;
    logic [SMP_W-1:0]       r_mag;

    logic [ACC_W-1:0]       abs_ext;
    logic [REM_W-1:0]       shifted;
    logic [REM_W:0]         trial;

    assign abs_ext = i_dividend[ACC_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign shifted = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= abs_ext[NUM_W-1:0];
            r_rem  <= '0;
            r_den  <= i_divisor;
            r_neg  <= i_dividend[ACC_W-1];
            r_zero <= (i_divisor == '0);
        end else if (r_busy && r_cnt != '0) begin
            if (!trial[REM_W]) begin
                r_rem <= trial[REM_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end else if (r_busy) begin
            // quotient magnitude never exceeds 2^(SMP_W-1)
            if (r_zero) begin
                r_mag  <= '0;
                r_quot <= '0;
            end else begin
                r_mag  <= r_num[SMP_W-1:0];
                r_quot <= r_neg ? -$signed({1'b0, r_num[SMP_W-1:0]})
                                : $signed({1'b0, r_num[SMP_W-1:0]});
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_mag  = r_mag;

endmodule

`default_nettype wire

FILE: src/dosc_ctrl.sv
// Controller: input/output handshakes and command sequencing.
`timescale 1ns / 1ps
`default_nettype none

module dosc_ctrl
    import dosc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       xfer_in;

    assign o_ready = (r_state == S_IDLE);
    assign xfer_in = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (xfer_in) begin
                    case (i_kind)
                        K_START: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_WRITE;
                        end
                        K_SAMPLE: begin
                            o_cmd.sample = 1'b1;
                        end
                        K_MARKER: begin
                            if (i_sts.phase == PH_WAIT) begin
                                o_cmd.open = 1'b1;
                            end else if (i_sts.phase == PH_INTEG) begin
                                o_cmd.div_start = 1'b1;
                                n_state         = S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.close = 1'b1;
                    n_state     = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: src/dosc_dp.sv
// Datapath: settings, calibration state, accumulator, divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module dosc_dp
    import dosc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [SMP_W-1:0]      i_sample_raw,
    input  wire logic                  i_sample_ok,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    output logic [15:0]                o_offset_code,
    output logic signed [15:0]         o_frame_average,
    output logic [9:0]                 o_iteration_count,
    output logic [1:0]                 o_status,
    output logic                       o_tx_enable
);

    logic [14:0] r_window;
    logic [14:0] r_deadband;
    logic [9:0]  r_max_iter;
    logic [15:0] r_init_ofs;

    logic [15:0]             r_offset,  n_offset;
    logic [9:0]              r_iter,    n_iter;
    logic signed [ACC_W-1:0] r_acc,     n_acc;
    logic [CNT_W-1:0]        r_cnt,     n_cnt;
    logic [1:0]              r_phase,   n_phase;
    logic                    r_tx,      n_tx;
    logic signed [15:0]      r_res_avg, n_res_avg;
    logic [1:0]              r_res_sts, n_res_sts;

    logic [15:0]        r_o_offset;
    logic signed [15:0] r_o_avg;
    logic [9:0]         r_o_iter;
    logic [1:0]         r_o_sts;
    logic               r_o_tx;

    logic                     div_done;
    logic signed [QUOT_W-1:0] quot;
    logic [SMP_W-1:0]         mag;
    logic [SMP_W-1:0]         smp;
    logic [15:0]              step;
    logic [9:0]               iter_inc;
    logic signed [QUOT_W-1:0] db_s;

    dosc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_mag      (mag)
    );

    // offset binary to two's complement
    assign smp      = i_sample_raw ^ {1'b1, {(SMP_W-1){1'b0}}};
    assign step     = (r_iter < 10'd16) ? (16'h8000 >> r_iter[3:0]) : 16'd1;
    assign iter_inc = r_iter + 10'd1;
    assign db_s     = $signed({2'b00, r_deadband});

    always_comb begin
        n_offset  = r_offset;
        n_iter    = r_iter;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_phase   = r_phase;
        n_tx      = r_tx;
        n_res_avg = r_res_avg;
        n_res_sts = r_res_sts;
        if (i_cmd.start) begin
            n_offset  = r_init_ofs;
            n_iter    = '0;
            n_acc     = '0;
            n_cnt     = '0;
            n_res_avg = '0;
            if (r_max_iter == '0) begin
                n_tx      = 1'b1;
                n_phase   = PH_IDLE;
                n_res_sts = ST_GAVE;
            end else begin
                n_tx      = 1'b0;
                n_phase   = PH_WAIT;
                n_res_sts = ST_CAL;
            end
        end
        if (i_cmd.sample && r_phase == PH_INTEG && r_cnt < CNT_W'(MAX_SAMPLES)) begin
            if (i_sample_ok) begin
                n_acc = r_acc + {{(ACC_W-SMP_W){smp[SMP_W-1]}}, smp};
            end
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.open) begin
            n_acc   = '0;
            n_cnt   = '0;
            n_phase = PH_INTEG;
        end
        if (i_cmd.close) begin
            n_res_avg = quot[15:0];
            n_res_sts = ST_CAL;
            if (mag <= {1'b0, r_window}) begin
                n_res_sts = ST_CONV;
            end else if (quot > db_s) begin
                n_offset = r_offset + step;
            end else if (quot < -db_s) begin
                n_offset = r_offset - step;
            end
            n_iter = iter_inc;
            n_acc  = '0;
            n_cnt  = '0;
            if (mag <= {1'b0, r_window}) begin
                n_tx    = 1'b1;
                n_phase = PH_IDLE;
            end else if (iter_inc >= r_max_iter) begin
                n_res_sts = ST_GAVE;
                n_tx      = 1'b1;
                n_phase   = PH_IDLE;
            end else begin
                n_phase = PH_WAIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= RST_WINDOW;
            r_deadband <= RST_DEADBAND;
            r_max_iter <= RST_MAX_ITER;
            r_init_ofs <= RST_INIT_OFS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW:   r_window   <= i_cfg_data[14:0];
                REG_DEADBAND: r_deadband <= i_cfg_data[14:0];
                REG_MAX_ITER: r_max_iter <= i_cfg_data[9:0];
                REG_INIT_OFS: r_init_ofs <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_iter   <= '0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_phase  <= PH_IDLE;
            r_tx     <= 1'b1;
        end else begin
            r_offset <= n_offset;
            r_iter   <= n_iter;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_phase  <= n_phase;
            r_tx     <= n_tx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_avg <= n_res_avg;
        r_res_sts <= n_res_sts;
        if (i_cmd.out_load) begin
            r_o_offset <= r_offset;
            r_o_avg    <= r_res_avg;
            r_o_iter   <= r_iter;
            r_o_sts    <= r_res_sts;
            r_o_tx     <= r_tx;
        end
    end

    assign o_sts.phase    = r_phase;
    assign o_sts.div_done = div_done;

    assign o_offset_code     = r_o_offset;
    assign o_frame_average   = r_o_avg;
    assign o_iteration_count = r_o_iter;
    assign o_status          = r_o_sts;
    assign o_tx_enable       = r_o_tx;

endmodule

`default_nettype wire

FILE: src/dc_offset_sar_calibrator.sv
// Top level of the successive-approximation DC offset calibrator.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  in       | i_valid / o_ready  | i_kind, i_sample_raw, i_sample_ok
//  out      | o_valid / i_ready  | o_offset_code, o_frame_average, o_iteration_count,
//           |                    | o_status, o_tx_enable
//  cfg      | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Sample ticks and opening markers leave the controller idle and ready; a start goes
// through the write state to the result register. A closing marker waits in the divide
// state on the bit-serial divider (one quotient bit per cycle, 26-bit sum magnitude).
// Samples are taken while a result waits; a result-producing item stalls until the
// result register is free. Synchronous active-low reset, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module dc_offset_sar_calibrator
    import dosc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [1:0]            i_kind,
    input  wire logic [15:0]           i_sample_raw,
    input  wire logic                  i_sample_ok,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [15:0]                o_offset_code,
    output logic signed [15:0]         o_frame_average,
    output logic [9:0]                 o_iteration_count,
    output logic [1:0]                 o_status,
    output logic                       o_tx_enable
);

    t_cmd cmd;
    t_sts sts;

    dosc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dosc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_sample_raw      (i_sample_raw),
        .i_sample_ok       (i_sample_ok),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_offset_code     (o_offset_code),
        .o_frame_average   (o_frame_average),
        .o_iteration_count (o_iteration_count),
        .o_status          (o_status),
        .o_tx_enable       (o_tx_enable)
    );

    a_tx_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_CAL |-> o_tx_enable)
        else $error("transmitter not restored on final result");

    a_tx_off_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_CAL |-> !o_tx_enable)
        else $error("transmitter enabled while calibrating");

    a_start_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_CAL && o_iteration_count == 10'd0
        |-> o_frame_average == 16'sd0)
        else $error("start result carries a nonzero average");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_offset_code)
            && $stable(o_frame_average) && $stable(o_iteration_count)
            && $stable(o_status) && $stable(o_tx_enable))
        else $error("result changed before transfer");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for the DC offset calibrator: a directed table, then random frames per setting.
`timescale 1ns / 1ps
module tb;
    import dosc_pkg::*;

    localparam logic [1:0]  K_SPARE     = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned DRAIN_CYC   = 40;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_ITEMS = 110;
    localparam int unsigned NUM_PHASES  = 6;
    localparam int unsigned LONG_FRAME  = MAX_SAMPLES + 6;

    typedef struct packed {
        logic [15:0]        ofs;
        logic signed [15:0] avg;
        logic [9:0]         iter;
        logic [1:0]         st;
        logic               tx;
    } t_cal_report;

    typedef struct packed {
        bit          cfg_wr;
        logic [1:0]  sel;
        logic [15:0] val;
        logic        ok;
        bit          pinned;
        t_cal_report want;
    } t_dir_row;

    localparam t_cal_report NO_REP    = '0;
    localparam t_cal_report START_REP = '{16'h8000, 16'sd0, 10'd0, ST_CAL, 1'b0};

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_kind       = K_SAMPLE;
    logic [15:0]           i_sample_raw = '0;
    logic                  i_sample_ok  = 1'b0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [15:0]           o_offset_code;
    logic signed [15:0]    o_frame_average;
    logic [9:0]            o_iteration_count;
    logic [1:0]            o_status;
    logic                  o_tx_enable;

    logic [14:0] win_lim;
    logic [14:0] dead_band;
    logic [9:0]  iter_lim;
    logic [15:0] start_ofs;
    logic [15:0] cal_ofs;
    logic [9:0]  cal_iter;
    longint      cal_sum;
    int unsigned cal_cnt;
    logic [1:0]  cal_phase;
    logic        cal_tx;

    t_cal_report report_q[$];
    t_cal_report seen_rep;
    t_cal_report due_rep;
    int unsigned err_cnt       = 0;
    int unsigned cycle_cnt     = 0;
    bit          snd_quiet     = 1'b0;
    bit          rcv_quiet     = 1'b0;
    bit          long_hold_req = 1'b0;

    t_dir_row dir_rows [29] = '{
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_SAMPLE, 16'hFFFF, 1'b1, 1'b0, NO_REP},
        '{1'b0, K_SPARE,  16'h1234, 1'b1, 1'b0, NO_REP},
        '{1'b0, K_START,  16'h0000, 1'b0, 1'b1, START_REP},
        '{1'b0, K_SAMPLE, 16'hFFFF, 1'b1, 1'b0, NO_REP},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b1,
          '{16'h8000, 16'sd0, 10'd1, ST_CONV, 1'b1}},
        '{1'b0, K_START,  16'h0000, 1'b0, 1'b1, START_REP},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_SAMPLE, 16'hFFFF, 1'b1, 1'b0, NO_REP},
        '{1'b0, K_SAMPLE, 16'hFFFF, 1'b1, 1'b0, NO_REP},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b1,
          '{16'h0000, 16'sd32767, 10'd1, ST_CAL, 1'b0}},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_SAMPLE, 16'h0000, 1'b1, 1'b0, NO_REP},
        '{1'b0, K_SAMPLE, 16'hFFFF, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_SAMPLE, 16'h0000, 1'b1, 1'b0, NO_REP},
        '{1'b0, K_START,  16'h0000, 1'b0, 1'b1, START_REP},
        '{1'b1, REG_MAX_ITER, 16'd0, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_START,  16'h0000, 1'b0, 1'b1,
          '{16'h8000, 16'sd0, 10'd0, ST_GAVE, 1'b1}},
        '{1'b1, REG_WINDOW,   16'd0,      1'b0, 1'b0, NO_REP},
        '{1'b1, REG_DEADBAND, 16'h7FFF,   1'b0, 1'b0, NO_REP},
        '{1'b1, REG_MAX_ITER, 16'd1,      1'b0, 1'b0, NO_REP},
        '{1'b1, REG_INIT_OFS, 16'hFFFF,   1'b0, 1'b0, NO_REP},
        '{1'b0, K_START,  16'h0000, 1'b0, 1'b1,
          '{16'hFFFF, 16'sd0, 10'd0, ST_CAL, 1'b0}},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP},
        '{1'b0, K_SAMPLE, 16'h8001, 1'b1, 1'b0, NO_REP},
        '{1'b0, K_MARKER, 16'h0000, 1'b0, 1'b1,
          '{16'hFFFF, 16'sd1, 10'd1, ST_GAVE, 1'b1}}
    };

    dc_offset_sar_calibrator DUT (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    function automatic void cal_reset();
        win_lim   = RST_WINDOW;
        dead_band = RST_DEADBAND;
        iter_lim  = RST_MAX_ITER;
        start_ofs = RST_INIT_OFS;
        cal_ofs   = '0;
        cal_iter  = '0;
        cal_sum   = 0;
        cal_cnt   = 0;
        cal_phase = PH_IDLE;
        cal_tx    = 1'b1;
    endfunction

    // Returns 1 when the item yields a report; used flags items that change state.
    function automatic bit sar_step(input logic [1:0] kind, input logic [15:0] raw,
                                    input logic ok, output t_cal_report rep, output bit used);
        longint      quo;
        int          avg;
        int          mag;
        logic [15:0] stride;
        logic [1:0]  st;
        rep  = '0;
        used = 1'b0;
        st   = ST_CAL;
        case (kind)
            K_START: begin
                cal_ofs  = start_ofs;
                cal_iter = '0;
                cal_sum  = 0;
                cal_cnt  = 0;
                if (iter_lim == '0) begin
                    cal_tx    = 1'b1;
                    cal_phase = PH_IDLE;
                    st        = ST_GAVE;
                end else begin
                    cal_tx    = 1'b0;
                    cal_phase = PH_WAIT;
                end
                rep  = '{cal_ofs, 16'sd0, cal_iter, st, cal_tx};
                used = 1'b1;
                return 1'b1;
            end
            K_SAMPLE: begin
                if (cal_phase == PH_INTEG && cal_cnt < MAX_SAMPLES) begin
                    if (ok)
                        cal_sum += longint'(raw) - 32768;
                    cal_cnt++;
                    used = 1'b1;
                end
                return 1'b0;
            end
            K_MARKER: begin
                if (cal_phase == PH_WAIT) begin
                    cal_sum   = 0;
                    cal_cnt   = 0;
                    cal_phase = PH_INTEG;
                    used      = 1'b1;
                    return 1'b0;
                end
                if (cal_phase == PH_INTEG) begin
                    quo    = (cal_cnt != 0) ? cal_sum / longint'(cal_cnt) : 0;
                    avg    = int'(quo);
                    mag    = (avg < 0) ? -avg : avg;
                    stride = (cal_iter < 10'd16) ? 16'(1 << (15 - int'(cal_iter))) : 16'd1;
                    if (mag <= int'(win_lim))
                        st = ST_CONV;
                    else if (avg > int'(dead_band))
                        cal_ofs = cal_ofs + stride;
                    else if (avg < -int'(dead_band))
                        cal_ofs = cal_ofs - stride;
                    cal_iter = cal_iter + 10'd1;
                    cal_sum  = 0;
                    cal_cnt  = 0;
                    if (st == ST_CONV) begin
                        cal_tx    = 1'b1;
                        cal_phase = PH_IDLE;
                    end else if (cal_iter >= iter_lim) begin
                        st        = ST_GAVE;
                        cal_tx    = 1'b1;
                        cal_phase = PH_IDLE;
                    end else begin
                        cal_phase = PH_WAIT;
                    end
                    rep  = '{cal_ofs, 16'(avg), cal_iter, st, cal_tx};
                    used = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic push_item(input logic [1:0] kind, input logic [15:0] raw, input logic ok,
                             input bit pinned, input t_cal_report want, output bit used);
        int unsigned gap;
        t_cal_report rep;
        gap = snd_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_sample_raw <= raw;
        i_sample_ok  <= ok;
        do @(posedge i_clk); while (!o_ready);
        if (sar_step(kind, raw, ok, rep, used))
            report_q.push_back(pinned ? want : rep);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_WINDOW:   win_lim   = data[14:0];
            REG_DEADBAND: dead_band = data[14:0];
            REG_MAX_ITER: iter_lim  = data[9:0];
            REG_INIT_OFS: start_ofs = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One measurement; a few lose the opening marker or end in a restart.
    task automatic send_frame(output int unsigned took);
        int unsigned spread;
        int unsigned jit;
        int unsigned len;
        int unsigned r;
        int          bias;
        int          v;
        bit          used;
        took = 0;
        r    = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       spread = 16;
            1:       spread = 300;
            2:       spread = 3000;
            default: spread = 32767;
        endcase
        bias = int'($urandom_range(0, 2 * spread)) - int'(spread);
        jit  = $urandom_range(0, 200);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        if (r >= 4) begin
            push_item(K_MARKER, 16'($urandom), 1'($urandom), 1'b0, NO_REP, used);
            took += used;
        end
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, 65535);
            else
                v = 32768 + bias + int'($urandom_range(0, 2 * jit)) - int'(jit);
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            push_item(K_SAMPLE, 16'(v), $urandom_range(0, 9) != 0, 1'b0, NO_REP, used);
            took += used;
        end
        push_item((r >= 4 && r < 8) ? K_START : K_MARKER, 16'($urandom), 1'($urandom),
                  1'b0, NO_REP, used);
        took += used;
    endtask

    initial begin : report_sink
        int unsigned hold;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            hold = rcv_quiet ? 0 : $urandom_range(0, 15);
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold != 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_rep = '{o_offset_code, o_frame_average, o_iteration_count, o_status,
                         o_tx_enable};
            if (report_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected report: ofs=%h avg=%0d iter=%0d st=%0d tx=%b",
                             seen_rep.ofs, seen_rep.avg, seen_rep.iter, seen_rep.st,
                             seen_rep.tx);
            end else begin
                due_rep = report_q.pop_front();
                if (seen_rep.ofs !== due_rep.ofs || seen_rep.avg !== due_rep.avg ||
                    seen_rep.iter !== due_rep.iter || seen_rep.st !== due_rep.st ||
                    seen_rep.tx !== due_rep.tx) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"report mismatch: exp ofs=%h avg=%0d iter=%0d st=%0d tx=%b",
                                  " / got ofs=%h avg=%0d iter=%0d st=%0d tx=%b"},
                                 due_rep.ofs, due_rep.avg, due_rep.iter, due_rep.st,
                                 due_rep.tx, seen_rep.ofs, seen_rep.avg, seen_rep.iter,
                                 seen_rep.st, seen_rep.tx);
                end
            end
        end
    end

    initial begin : stim
        bit          used;
        int unsigned done;
        int unsigned took;
        int unsigned r;
        logic [14:0] w_val;
        logic [14:0] d_val;
        logic [9:0]  m_val;
        logic [15:0] o_val;
        cal_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_wr) begin
                settle();
                cfg_write(dir_rows[i].sel, dir_rows[i].val);
            end else begin
                push_item(dir_rows[i].sel, dir_rows[i].val, dir_rows[i].ok,
                          dir_rows[i].pinned, dir_rows[i].want, used);
            end
        end

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    w_val = RST_WINDOW;
                    d_val = RST_DEADBAND;
                    m_val = RST_MAX_ITER;
                    o_val = RST_INIT_OFS;
                end
                1: begin
                    w_val = '0;
                    d_val = '0;
                    m_val = 10'd16;
                    o_val = 16'h0000;
                end
                2: begin
                    w_val = 15'h7FFF;
                    d_val = 15'h7FFF;
                    m_val = 10'd1023;
                    o_val = 16'hFFFF;
                end
                3: begin
                    w_val = 15'($urandom_range(0, 2000));
                    d_val = 15'($urandom_range(0, w_val));
                    m_val = 10'($urandom_range(1, 20));
                    o_val = 16'($urandom);
                end
                4: begin
                    w_val = 15'd100;
                    d_val = 15'd200;
                    m_val = 10'd3;
                    o_val = 16'($urandom);
                end
                default: begin
                    w_val = 15'($urandom);
                    d_val = 15'($urandom);
                    m_val = 10'($urandom_range(1, 1023));
                    o_val = 16'($urandom);
                end
            endcase
            cfg_write(REG_WINDOW, {1'b0, w_val});
            cfg_write(REG_DEADBAND, {1'b0, d_val});
            cfg_write(REG_MAX_ITER, {6'd0, m_val});
            cfg_write(REG_INIT_OFS, o_val);
            snd_quiet = (ph == 1 || ph == 4);
            rcv_quiet = (ph == 4);
            if (ph == 1)
                long_hold_req = 1'b1;

            // overfull measurement, back to back
            if (ph == 0) begin
                snd_quiet = 1'b1;
                push_item(K_START, 16'h0000, 1'b0, 1'b0, NO_REP, used);
                push_item(K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP, used);
                for (int unsigned k = 0; k < LONG_FRAME; k++)
                    push_item(K_SAMPLE, 16'($urandom), 1'b1, 1'b0, NO_REP, used);
                push_item(K_MARKER, 16'h0000, 1'b0, 1'b0, NO_REP, used);
                snd_quiet = 1'b0;
            end

            done = 0;
            while (done < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if ((cal_phase == PH_IDLE && r < 85) || r < 5) begin
                    push_item(K_START, 16'($urandom), 1'($urandom), 1'b0, NO_REP, used);
                    done += used;
                end else if (r < 12) begin
                    push_item(2'($urandom), 16'($urandom), 1'($urandom), 1'b0, NO_REP, used);
                    done += used;
                end else begin
                    send_frame(took);
                    done += took;
                end
            end
        end

        settle();
        if (err_cnt == 0 && report_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
src/dosc_pkg.sv
src/dosc_div.sv
src/dosc_ctrl.sv
src/dosc_dp.sv
src/dc_offset_sar_calibrator.sv
verif/tb.sv
